FILE: sv/elliptical_fade_mask_defines.svh
// Assertion macros shared by the elliptical fade mask RTL.
`ifndef ELLIPTICAL_FADE_MASK_DEFINES_SVH
`define ELLIPTICAL_FADE_MASK_DEFINES_SVH

`ifndef ASSERT_OFF
`define EFM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EFM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define EFM_ASSERT(lbl, prop, msg)
`define EFM_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

FILE: sv/efm_pkg.sv
// Package with constants for the elliptical fade mask.
`timescale 1ns / 1ps
`default_nettype none

package efm_pkg;

  localparam int DEF_COORD_BITS = 12;
  localparam int DEF_FRAC_BITS  = 16;

  localparam int REG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int DEN_W     = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic [REG_W-1:0] FRAME_WIDTH_RST  = 13'd500;
  localparam logic [REG_W-1:0] FRAME_HEIGHT_RST = 13'd600;

  localparam int GRAY_R = 11;
  localparam int GRAY_G = 16;
  localparam int GRAY_B = 5;

  localparam int AXIS_SCALE = 100;
  localparam int AXIS_DEN   = 94;
  localparam int BAND_DEN   = 10;

endpackage

`default_nettype wire

FILE: sv/elliptical_fade_mask.sv
// Top level of the elliptical fade mask pixel pipeline.
//
// The block turns a stream of RGB pixels into gray levels faded toward
// white outside a centered ellipse. Each input transaction carries the
// pixel column, row and RGB bytes; each output transaction carries one
// masked gray byte, in the same order as the inputs.
// The frame size is set through the configuration channel, which is
// always ready; it should be written only while no pixel is in flight.
// One pixel enters per clock unless the receiver stalls. The depth is
// set by the axis dividers, the square root and the fade divider,
// each of which resolves one bit per stage.
// When the receiver stalls, the whole pipeline holds and in_stall rises
// in the same cycle, so no pixel is lost or repeated.
// Reset clears all valid bits and loads a 500 by 600 frame size.
`timescale 1ns / 1ps
`default_nettype none
`include "elliptical_fade_mask_defines.svh"

module elliptical_fade_mask #(
  parameter int COORD_BITS = efm_pkg::DEF_COORD_BITS,
  parameter int FRAC_BITS  = efm_pkg::DEF_FRAC_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [efm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [efm_pkg::REG_W-1:0]     cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [COORD_BITS-1:0]        in_col,
  input  wire logic [COORD_BITS-1:0]        in_row,
  input  wire logic [7:0]                   in_red,
  input  wire logic [7:0]                   in_green,
  input  wire logic [7:0]                   in_blue,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [7:0]                        out_masked_gray
);
  import efm_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int OW  = (COORD_BITS + 1 > REG_W) ? COORD_BITS + 1 : REG_W;
  localparam int AW  = OW + 7;
  localparam int DW  = (F > DEN_W) ? F : DEN_W;
  localparam int CW  = (AW > DW + 1) ? AW : DW + 1;
  localparam int QW  = F + 1;
  localparam int NW  = F + 2;
  localparam int VW  = 2 * NW;
  localparam int RW  = NW + 1;
  localparam int TW  = F + 2;
  localparam int SW  = F + 3;
  localparam int BW  = F + 9;

  localparam logic [NW-1:0] ONE_N = NW'(1) << F;
  localparam logic [NW-1:0] CAP_N = NW'(1) << (F + 1);
  localparam logic [QW-1:0] ONE_Q = QW'(1) << F;
  localparam logic [SW-1:0] ONE_S = SW'(1) << F;
  localparam logic [TW-1:0] THREE_ONE = TW'(3) << F;

  typedef struct packed {
    logic [DW-1:0] r;
    logic [QW-1:0] q;
  } div_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] gray;
    logic       satx;
    logic       saty;
    div_t       x;
    div_t       y;
    div_t       b;
  } front_t;

  typedef struct packed {
    logic          vld;
    logic [7:0]    gray;
    logic [F-1:0]  band;
    logic [VW-1:0] nx2;
    logic [VW-1:0] ny2;
  } sq_t;

  typedef struct packed {
    logic          vld;
    logic [7:0]    gray;
    logic [F-1:0]  band;
    logic [VW-1:0] vs;
    logic [RW-1:0] rem;
    logic [NW-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic         vld;
    logic [7:0]   gray;
    logic         outside;
    logic         inband;
    logic [F-1:0] band;
    div_t         p;
  } pdiv_t;

  typedef struct packed {
    logic          vld;
    logic [7:0]    gray;
    logic          outside;
    logic          inband;
    logic [QW-1:0] p2;
    logic [TW-1:0] t3;
  } m1_t;

  typedef struct packed {
    logic          vld;
    logic [7:0]    gray;
    logic          outside;
    logic          inband;
    logic [QW-1:0] a;
  } m2_t;

  function automatic div_t div_adv(input div_t x, input logic [DW:0] rr,
                                   input logic [DW-1:0] d);
    div_t        y;
    logic        ge;
    logic [DW:0] diff;
    ge   = (rr >= {1'b0, d});
    diff = rr - {1'b0, d};
    y.q  = {x.q[QW-2:0], ge};
    y.r  = ge ? diff[DW-1:0] : rr[DW-1:0];
    return y;
  endfunction

  function automatic sqrt_t sqrt_adv(input sqrt_t x);
    sqrt_t         y;
    logic [RW+1:0] r2;
    logic [RW+1:0] t;
    y  = x;
    r2 = {x.rem, x.vs[VW-1 -: 2]};
    t  = (RW + 2)'({x.root, 2'b01});
    if (r2 >= t) begin
      y.rem  = RW'(r2 - t);
      y.root = {x.root[NW-2:0], 1'b1};
    end else begin
      y.rem  = r2[RW-1:0];
      y.root = {x.root[NW-2:0], 1'b0};
    end
    y.vs = x.vs << 2;
    return y;
  endfunction

  logic [REG_W-1:0] fw_r;
  logic [REG_W-1:0] fh_r;

  logic [REG_W-1:0] w_eff;
  logic [REG_W-1:0] h_eff;
  logic [REG_W-1:0] mn;
  logic [DW-1:0]    dx;
  logic [DW-1:0]    dy;
  logic [DW-1:0]    db;

  logic en;

  front_t fr_r   [0:F];
  front_t fr_nxt [0:F];
  sq_t    sq_r;
  sq_t    sq_nxt;
  sqrt_t  sum_r;
  sqrt_t  sum_nxt;
  sqrt_t  sr_r   [0:NW-1];
  sqrt_t  sr_nxt [0:NW-1];
  pdiv_t  pd_r   [0:F];
  pdiv_t  pd_nxt [0:F];
  m1_t    m1_r;
  m1_t    m1_nxt;
  m2_t    m2_r;
  m2_t    m2_nxt;
  logic       out_vld_r;
  logic [7:0] out_gray_r;
  logic [7:0] out_gray_nxt;

  assign cfg_ready       = 1'b1;
  assign en              = ~(out_vld_r & out_stall);
  assign in_stall        = ~en;
  assign out_valid       = out_vld_r;
  assign out_masked_gray = out_gray_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FRAME_WIDTH_RST;
      fh_r <= FRAME_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  fw_r <= cfg_data;
        CFG_FRAME_HEIGHT: fh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = (fw_r == '0) ? REG_W'(1) : fw_r;
    h_eff = (fh_r == '0) ? REG_W'(1) : fh_r;
    mn    = (w_eff < h_eff) ? w_eff : h_eff;
    dx    = DW'(w_eff) * DW'(AXIS_DEN);
    dy    = DW'(h_eff) * DW'(AXIS_DEN);
    db    = DW'(w_eff) * DW'(BAND_DEN);
  end

  // Front stage: gray level, axis offsets and the first divider step.
  always_comb begin
    logic [12:0]   gsum;
    logic [OW-1:0] twx;
    logic [OW-1:0] twy;
    logic [OW-1:0] wx;
    logic [OW-1:0] hy;
    logic [OW-1:0] offx;
    logic [OW-1:0] offy;
    logic [CW-1:0] ax;
    logic [CW-1:0] ay;
    gsum = 13'(in_red) * 13'(GRAY_R) + 13'(in_green) * 13'(GRAY_G)
         + 13'(in_blue) * 13'(GRAY_B);
    twx  = OW'({in_col, 1'b0});
    twy  = OW'({in_row, 1'b0});
    wx   = OW'(w_eff);
    hy   = OW'(h_eff);
    offx = (twx >= wx) ? twx - wx : wx - twx;
    offy = (twy >= hy) ? twy - hy : hy - twy;
    ax   = CW'(AW'(offx) * AW'(AXIS_SCALE));
    ay   = CW'(AW'(offy) * AW'(AXIS_SCALE));
    fr_nxt[0].vld  = in_valid;
    fr_nxt[0].gray = gsum[12:5];
    fr_nxt[0].satx = ax >= CW'({dx, 1'b0});
    fr_nxt[0].saty = ay >= CW'({dy, 1'b0});
    fr_nxt[0].x    = div_adv('0, ax[DW:0], dx);
    fr_nxt[0].y    = div_adv('0, ay[DW:0], dy);
    fr_nxt[0].b    = div_adv('0, (DW + 1)'(mn), db);
    for (int k = 1; k <= F; k++) begin
      fr_nxt[k]   = fr_r[k-1];
      fr_nxt[k].x = div_adv(fr_r[k-1].x, {fr_r[k-1].x.r, 1'b0}, dx);
      fr_nxt[k].y = div_adv(fr_r[k-1].y, {fr_r[k-1].y.r, 1'b0}, dy);
      fr_nxt[k].b = div_adv(fr_r[k-1].b, {fr_r[k-1].b.r, 1'b0}, db);
    end
  end

  always_comb begin
    logic [NW-1:0] nx;
    logic [NW-1:0] ny;
    nx = fr_r[F].satx ? CAP_N : NW'(fr_r[F].x.q);
    ny = fr_r[F].saty ? CAP_N : NW'(fr_r[F].y.q);
    sq_nxt.vld  = fr_r[F].vld;
    sq_nxt.gray = fr_r[F].gray;
    sq_nxt.band = fr_r[F].b.q[F-1:0];
    sq_nxt.nx2  = VW'(nx) * VW'(nx);
    sq_nxt.ny2  = VW'(ny) * VW'(ny);
  end

  always_comb begin
    sum_nxt.vld  = sq_r.vld;
    sum_nxt.gray = sq_r.gray;
    sum_nxt.band = sq_r.band;
    sum_nxt.vs   = sq_r.nx2 + sq_r.ny2;
    sum_nxt.rem  = '0;
    sum_nxt.root = '0;
    for (int k = 0; k < NW; k++) begin
      sr_nxt[k] = sqrt_adv((k == 0) ? sum_r : sr_r[(k == 0) ? 0 : k - 1]);
    end
  end

  // Band test on the distance and the first step of the fade divider.
  always_comb begin
    logic [NW-1:0] dist_q;
    logic [NW-1:0] edge_q;
    logic [NW-1:0] ap;
    dist_q = sr_r[NW-1].root;
    edge_q = ONE_N - NW'(sr_r[NW-1].band);
    ap     = dist_q - edge_q;
    pd_nxt[0].vld     = sr_r[NW-1].vld;
    pd_nxt[0].gray    = sr_r[NW-1].gray;
    pd_nxt[0].outside = dist_q > ONE_N;
    pd_nxt[0].inband  = (sr_r[NW-1].band != '0) && (dist_q > edge_q);
    pd_nxt[0].band    = sr_r[NW-1].band;
    pd_nxt[0].p       = div_adv('0, (DW + 1)'(ap), DW'(sr_r[NW-1].band));
    for (int k = 1; k <= F; k++) begin
      pd_nxt[k]   = pd_r[k-1];
      pd_nxt[k].p = div_adv(pd_r[k-1].p, {pd_r[k-1].p.r, 1'b0},
                            DW'(pd_r[k-1].band));
    end
  end

  always_comb begin
    logic [QW-1:0]   p;
    logic [2*QW-1:0] psq;
    p   = pd_r[F].p.q;
    psq = (2 * QW)'(p) * (2 * QW)'(p);
    m1_nxt.vld     = pd_r[F].vld;
    m1_nxt.gray    = pd_r[F].gray;
    m1_nxt.outside = pd_r[F].outside;
    m1_nxt.inband  = pd_r[F].inband;
    m1_nxt.p2      = psq[F +: QW];
    m1_nxt.t3      = THREE_ONE - TW'({p, 1'b0});
  end

  always_comb begin
    logic [QW+TW-1:0] sp;
    logic [SW-1:0]    s;
    logic [QW-1:0]    sc;
    sp = (QW + TW)'(m1_r.p2) * (QW + TW)'(m1_r.t3);
    s  = sp[F +: SW];
    sc = (s > ONE_S) ? ONE_Q : s[QW-1:0];
    m2_nxt.vld     = m1_r.vld;
    m2_nxt.gray    = m1_r.gray;
    m2_nxt.outside = m1_r.outside;
    m2_nxt.inband  = m1_r.inband;
    m2_nxt.a       = ONE_Q - sc;
  end

  always_comb begin
    logic [QW-1:0] na;
    logic [BW-1:0] ga;
    logic [BW-1:0] wa;
    logic [BW-1:0] bl;
    logic [8:0]    br;
    na = ONE_Q - m2_r.a;
    ga = BW'(m2_r.gray) * BW'(m2_r.a);
    wa = (BW'(na) << 8) - BW'(na);
    bl = ga + wa;
    br = bl[F +: 9];
    if (m2_r.outside) begin
      out_gray_nxt = 8'hFF;
    end else if (m2_r.inband) begin
      out_gray_nxt = (br > 9'd255) ? 8'hFF : br[7:0];
    end else begin
      out_gray_nxt = m2_r.gray;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= F; k++) begin
        fr_r[k].vld <= 1'b0;
        pd_r[k].vld <= 1'b0;
      end
      for (int k = 0; k < NW; k++) begin
        sr_r[k].vld <= 1'b0;
      end
      sq_r.vld  <= 1'b0;
      sum_r.vld <= 1'b0;
      m1_r.vld  <= 1'b0;
      m2_r.vld  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      for (int k = 0; k <= F; k++) begin
        fr_r[k] <= fr_nxt[k];
        pd_r[k] <= pd_nxt[k];
      end
      for (int k = 0; k < NW; k++) begin
        sr_r[k] <= sr_nxt[k];
      end
      sq_r       <= sq_nxt;
      sum_r      <= sum_nxt;
      m1_r       <= m1_nxt;
      m2_r       <= m2_nxt;
      out_vld_r  <= m2_r.vld;
      out_gray_r <= out_gray_nxt;
    end
  end

  `EFM_ASSERT(a_accept_enters_front, (in_valid && !in_stall) |=> fr_r[0].vld, "accepted pixel lost at the front stage")
  `EFM_ASSERT(a_outside_is_white, (m2_r.vld && m2_r.outside && en) |=> (out_gray_r == 8'hFF), "pixel outside the ellipse not white")
  `EFM_ASSERT_NEVER(a_p2_bounded, m1_r.vld && m1_r.inband && !m1_r.outside && (m1_r.p2 > ONE_Q), "fade position square exceeds one")

endmodule

`default_nettype wire
